@@ rtl/ipatc_pkg.sv @@
// Shared types and constants for the address text classifier.
// No dependencies; used by every module in rtl/ except ipatc_checker.
`timescale 1ns / 1ps

package ipatc_pkg;

    // Separator and digit codes (ASCII)
    localparam logic [7:0] DOT_CHAR      = 8'h2E;
    localparam logic [7:0] COLON_CHAR    = 8'h3A;
    localparam logic [7:0] DEC_LO        = 8'h30;
    localparam logic [7:0] DEC_HI        = 8'h39;
    localparam logic [7:0] UHEX_LO       = 8'h41;
    localparam logic [7:0] UHEX_HI       = 8'h46;
    localparam logic [7:0] LHEX_LO       = 8'h61;
    localparam logic [7:0] LHEX_HI       = 8'h66;

    // Address rules
    localparam logic [2:0] V4_DOTS       = 3'd3;
    localparam logic [2:0] V4_DOT_SAT    = 3'd4;
    localparam logic [3:0] V6_COLONS     = 4'd7;
    localparam logic [3:0] V6_COLON_SAT  = 4'd8;
    localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
    localparam logic [2:0] V4_LEN_SAT    = 3'd4;
    localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
    localparam logic [2:0] V6_LEN_SAT    = 3'd5;
    localparam logic [9:0] V4_MAX_VALUE  = 10'd255;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result codes
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2
    } kind_t;

    // One decoded character as handed from front to back
    typedef struct packed {
        logic       has_char;
        logic       last;
        logic       is_dot;
        logic       is_colon;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

endpackage

@@ rtl/ipatc_front.sv @@
// Front end: takes input beats and decodes each byte into a character class.
// Depends on ipatc_pkg.
`timescale 1ns / 1ps

module ipatc_front
    import ipatc_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  character,
    input  logic        has_char,
    input  logic        last,
    input  logic        q_ready,
    output logic        q_push,
    output char_class_t q_data
);

    logic is_dec;
    logic is_hex;

    assign is_dec = (character >= DEC_LO) && (character <= DEC_HI);
    assign is_hex = is_dec
                 || ((character >= UHEX_LO) && (character <= UHEX_HI))
                 || ((character >= LHEX_LO) && (character <= LHEX_HI));

    // Accept whenever the queue has room
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // Character classification
    always_comb
    begin
        q_data.has_char = has_char;
        q_data.last     = last;
        q_data.is_dot   = (character == DOT_CHAR);
        q_data.is_colon = (character == COLON_CHAR);
        q_data.is_dec   = is_dec;
        q_data.is_hex   = is_hex;
        q_data.digit    = character[3:0];
    end

endmodule

@@ rtl/ipatc_queue.sv @@
// Short register FIFO of decoded characters between front and back.
// Depends on ipatc_pkg.
`timescale 1ns / 1ps

module ipatc_queue
    import ipatc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    output logic        not_full,
    input  logic        pop,
    output logic        not_empty,
    output char_class_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    char_class_t      entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/ipatc_back.sv @@
// Back end: runs the IPv4 / IPv6 checks per character and registers the verdict.
// Depends on ipatc_pkg.
`timescale 1ns / 1ps

module ipatc_back
    import ipatc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  char_class_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output kind_t       kind
);

    logic [2:0] dot_count_reg,   dot_count_next;
    logic [3:0] colon_count_reg, colon_count_next;
    logic       v4_valid_reg,    v4_valid_next;
    logic       v6_valid_reg,    v6_valid_next;
    logic [2:0] v4_len_reg,      v4_len_next;
    logic [2:0] v6_len_reg,      v6_len_next;
    logic [9:0] v4_value_reg,    v4_value_next;
    logic       v4_lz_reg,       v4_lz_next;
    logic       out_valid_reg,   out_valid_next;
    kind_t      kind_reg,        kind_next;

    logic       v4_part_ok;
    logic       v6_part_ok;
    logic       v4_part_ok_new;
    logic       v6_part_ok_new;
    logic [9:0] value_times_ten;
    kind_t      verdict;

    // Head can move on unless it ends a string and the result slot is blocked
    assign q_pop = q_valid && (!q_head.last || !out_valid_reg || m_tready);

    // Part checks on the current (pre-update) part
    assign v4_part_ok = (v4_len_reg != 3'd0) && (v4_len_reg <= V4_MAX_DIGITS)
                     && (v4_value_reg <= V4_MAX_VALUE)
                     && !(v4_lz_reg && (v4_len_reg > 3'd1));
    assign v6_part_ok = (v6_len_reg != 3'd0) && (v6_len_reg <= V6_MAX_DIGITS);

    assign value_times_ten = {v4_value_reg[6:0], 3'b000} + {v4_value_reg[8:0], 1'b0};

    // Per-character state update
    always_comb
    begin
        dot_count_next   = dot_count_reg;
        colon_count_next = colon_count_reg;
        v4_valid_next    = v4_valid_reg;
        v6_valid_next    = v6_valid_reg;
        v4_len_next      = v4_len_reg;
        v6_len_next      = v6_len_reg;
        v4_value_next    = v4_value_reg;
        v4_lz_next       = v4_lz_reg;
        if (q_head.has_char)
        begin
            if (q_head.is_dot)
            begin
                if (dot_count_reg < V4_DOT_SAT)
                begin
                    dot_count_next = dot_count_reg + 1'b1;
                end
                if (!v4_part_ok)
                begin
                    v4_valid_next = 1'b0;
                end
                v4_len_next   = '0;
                v4_value_next = '0;
                v4_lz_next    = 1'b0;
                v6_valid_next = 1'b0;
            end
            else if (q_head.is_colon)
            begin
                if (colon_count_reg < V6_COLON_SAT)
                begin
                    colon_count_next = colon_count_reg + 1'b1;
                end
                if (!v6_part_ok)
                begin
                    v6_valid_next = 1'b0;
                end
                v6_len_next   = '0;
                v4_valid_next = 1'b0;
            end
            else
            begin
                if (q_head.is_dec)
                begin
                    if (v4_len_reg == 3'd0)
                    begin
                        v4_lz_next = (q_head.digit == 4'd0);
                    end
                    if (v4_len_reg < V4_MAX_DIGITS)
                    begin
                        v4_value_next = value_times_ten + {6'd0, q_head.digit};
                    end
                    if (v4_len_reg < V4_LEN_SAT)
                    begin
                        v4_len_next = v4_len_reg + 1'b1;
                    end
                end
                else
                begin
                    v4_valid_next = 1'b0;
                end
                if (q_head.is_hex)
                begin
                    if (v6_len_reg < V6_LEN_SAT)
                    begin
                        v6_len_next = v6_len_reg + 1'b1;
                    end
                end
                else
                begin
                    v6_valid_next = 1'b0;
                end
            end
        end
    end

    // Verdict from the updated state
    assign v4_part_ok_new = (v4_len_next != 3'd0) && (v4_len_next <= V4_MAX_DIGITS)
                         && (v4_value_next <= V4_MAX_VALUE)
                         && !(v4_lz_next && (v4_len_next > 3'd1));
    assign v6_part_ok_new = (v6_len_next != 3'd0) && (v6_len_next <= V6_MAX_DIGITS);

    always_comb
    begin
        verdict = KIND_NONE;
        if (dot_count_next == V4_DOTS)
        begin
            if (v4_valid_next && v4_part_ok_new)
            begin
                verdict = KIND_V4;
            end
        end
        else if (colon_count_next == V6_COLONS)
        begin
            if (v6_valid_next && v6_part_ok_new)
            begin
                verdict = KIND_V6;
            end
        end
    end

    // Result slot
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        kind_next      = kind_reg;
        if (q_pop && q_head.last)
        begin
            out_valid_next = 1'b1;
            kind_next      = verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_count_reg   <= '0;
            colon_count_reg <= '0;
            v4_valid_reg    <= 1'b1;
            v6_valid_reg    <= 1'b1;
            v4_len_reg      <= '0;
            v6_len_reg      <= '0;
            v4_value_reg    <= '0;
            v4_lz_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (q_head.last)
                begin
                    // string done, start fresh
                    dot_count_reg   <= '0;
                    colon_count_reg <= '0;
                    v4_valid_reg    <= 1'b1;
                    v6_valid_reg    <= 1'b1;
                    v4_len_reg      <= '0;
                    v6_len_reg      <= '0;
                    v4_value_reg    <= '0;
                    v4_lz_reg       <= 1'b0;
                end
                else
                begin
                    dot_count_reg   <= dot_count_next;
                    colon_count_reg <= colon_count_next;
                    v4_valid_reg    <= v4_valid_next;
                    v6_valid_reg    <= v6_valid_next;
                    v4_len_reg      <= v4_len_next;
                    v6_len_reg      <= v6_len_next;
                    v4_value_reg    <= v4_value_next;
                    v4_lz_reg       <= v4_lz_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign kind     = kind_reg;

endmodule

@@ rtl/ip_address_text_classifier.sv @@
// Address text classifier: IPv4 / IPv6 / neither verdict per string.
// Top level; depends on ipatc_pkg, ipatc_front, ipatc_queue, ipatc_back.
//
// Usage:
//   Input stream (s_*): one text byte per beat, s_tdata[7:0] = character,
//   s_tuser = has_char, s_tlast = last byte of the string. An empty string
//   is one beat with s_tuser low and s_tlast high.
//   Output stream (m_*): one beat per string, m_tdata[1:0] = class
//   (0 neither, 1 IPv4, 2 IPv6), sent after the beat marked last.
//   Throughput: one input beat per cycle while the queue has room. Per-character checks
//   are combinational logic in the back end.
//   Path: the last beat waits in the front-to-back queue, then the verdict is
//   registered into the result slot, which drives m_tvalid.
//   Stalls: while m_tready is low the result holds; the back end keeps
//   consuming non-final bytes and the queue of QUEUE_DEPTH beats fills
//   before s_tready drops.
//   Reset: rst_n clears the queue, the result slot and the string state;
//   the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module ip_address_text_classifier
    import ipatc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tuser,   // [0] has_char
    input  logic       s_tlast,   // last byte of the string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] address_kind, [7:2] zero
);

    char_class_t push_data;
    char_class_t head;
    logic        push;
    logic        pop;
    logic        q_not_full;
    logic        q_not_empty;
    kind_t       kind;

    ipatc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .character (s_tdata),
        .has_char  (s_tuser),
        .last      (s_tlast),
        .q_ready   (q_not_full),
        .q_push    (push),
        .q_data    (push_data)
    );

    ipatc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    ipatc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .kind     (kind)
    );

    assign m_tdata = {6'd0, kind};

endmodule

@@ rtl/ipatc_checker.sv @@
// Port-level checks for the address text classifier, bound to the top level.
// Depends on ip_address_text_classifier.
`timescale 1ns / 1ps

module ipatc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // Only the three defined classes, upper bits zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] != 2'd3))
        else $error("undefined class on output");

    // Input backpressure only comes from a pending, unaccepted result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // With the output idle and no input offered, the input is open right after
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !s_tvalid |=> s_tready)
        else $error("input closed with nothing pending");

endmodule

bind ip_address_text_classifier ipatc_checker u_ipatc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb.sv @@
// Self-checking testbench for ip_address_text_classifier: address strings stream in
// one byte per beat and a scoreboard predicts the class of each string.
// Depends on rtl/ipatc_pkg.sv and rtl/ip_address_text_classifier.sv.
`timescale 1ns / 1ps

module tb;
    import ipatc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int ITEMS_PER_PHASE = 150;

    // Predicts the class of each string and checks the result beats in order
    class kind_scoreboard;
        logic [2:0] dots;
        logic [3:0] colons;
        logic       v4_ok;
        logic       v6_ok;
        logic [2:0] v4_len;
        logic [2:0] v6_len;
        logic [9:0] v4_val;
        logic       v4_lead0;
        kind_t      expected_kinds[$];
        int         mismatches;

        function new();
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            dots     = '0;
            colons   = '0;
            v4_ok    = 1'b1;
            v6_ok    = 1'b1;
            v4_len   = '0;
            v6_len   = '0;
            v4_val   = '0;
            v4_lead0 = 1'b0;
        endfunction

        function bit v4_part_good();
            return v4_len != 0 && v4_len <= V4_MAX_DIGITS && v4_val <= V4_MAX_VALUE
                && !(v4_lead0 && v4_len > 1);
        endfunction

        function bit v6_part_good();
            return v6_len != 0 && v6_len <= V6_MAX_DIGITS;
        endfunction

        // Advance both readings by one text byte
        function void take_byte(logic [7:0] c);
            bit dec;
            bit hex;
            dec = c >= DEC_LO && c <= DEC_HI;
            hex = dec || (c >= UHEX_LO && c <= UHEX_HI) || (c >= LHEX_LO && c <= LHEX_HI);
            if (c == DOT_CHAR)
            begin
                if (dots < V4_DOT_SAT)
                    dots++;
                if (!v4_part_good())
                    v4_ok = 1'b0;
                v4_len   = '0;
                v4_val   = '0;
                v4_lead0 = 1'b0;
                v6_ok    = 1'b0;
            end
            else if (c == COLON_CHAR)
            begin
                if (colons < V6_COLON_SAT)
                    colons++;
                if (!v6_part_good())
                    v6_ok = 1'b0;
                v6_len = '0;
                v4_ok  = 1'b0;
            end
            else
            begin
                if (dec)
                begin
                    if (v4_len == 0)
                        v4_lead0 = (c == DEC_LO);
                    // value only tracks the first three digits, 10-bit wrap
                    if (v4_len < V4_MAX_DIGITS)
                        v4_val = 10'(v4_val * 10 + (c - DEC_LO));
                    if (v4_len < V4_LEN_SAT)
                        v4_len++;
                end
                else
                    v4_ok = 1'b0;
                if (hex)
                begin
                    if (v6_len < V6_LEN_SAT)
                        v6_len++;
                end
                else
                    v6_ok = 1'b0;
            end
        endfunction

        // Accepted input beat: update state, queue a verdict on the last beat
        function void note_beat(logic [7:0] c, logic has, logic fin);
            kind_t k;
            if (has)
                take_byte(c);
            if (fin)
            begin
                k = KIND_NONE;
                // three dots decide on the IPv4 reading alone
                if (dots == V4_DOTS)
                begin
                    if (v4_ok && v4_part_good())
                        k = KIND_V4;
                end
                else if (colons == V6_COLONS)
                begin
                    if (v6_ok && v6_part_good())
                        k = KIND_V6;
                end
                expected_kinds.insert(expected_kinds.size(), k);
                clear_string();
            end
        endfunction

        // Accepted result beat: compare against the oldest verdict
        function void check_kind(logic [7:0] data);
            kind_t want;
            if (expected_kinds.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual %0d",
                         $time, data);
                mismatches++;
                return;
            end
            want = expected_kinds.pop_front();
            if (data !== {6'b0, want})
            begin
                $display("%0t: address_kind mismatch: expected %0d, actual %0d",
                         $time, want, data);
                mismatches++;
            end
        endfunction

        function void report_leftover();
            if (expected_kinds.size() != 0)
            begin
                $display("%0t: %0d results missing: expected %0d first, actual none",
                         $time, expected_kinds.size(), expected_kinds[0]);
                mismatches += expected_kinds.size();
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    int             send_idle;
    int             recv_idle;
    int             beats_sent;
    int             cycle_count;
    logic [7:0]     text[$];
    kind_scoreboard sb;

    ip_address_text_classifier u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] character
        .s_tuser  (s_tuser),   // [0] has_char
        .s_tlast  (s_tlast),   // last byte of the string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [1:0] address_kind, [7:2] zero
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_kind(m_tdata);

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL ip_address_text_classifier");
        $finish;
    end

    // One input beat, with random idle cycles ahead of it
    task send_beat(input logic [7:0] c, input logic has, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(c, has, fin);
        beats_sent++;
    endtask

    // Send the text buffer as one string
    task send_text(input bit absent_end, input int ignore_pct);
        int i;
        if (text.size() == 0)
        begin
            send_beat(8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(99) < ignore_pct)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(text[i], 1'b1, !absent_end && i == text.size() - 1);
        end
        if (absent_end)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Append one byte to the text buffer
    function void put_char(logic [7:0] c);
        text.insert(text.size(), c);
    endfunction

    function void load_text(string s);
        int i;
        text.delete();
        for (i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function void add_number(int value, bit lead0);
        string s;
        int    i;
        s = $sformatf("%0d", value);
        if (lead0)
            put_char(DEC_LO);
        for (i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    // Mostly legal decimal parts, some out of range, padded or too long
    function void add_v4_part();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            add_number($urandom_range(255), 1'b0);
        else if (r < 80)
            add_number($urandom_range(99), 1'b1);
        else if (r < 88)
            add_number($urandom_range(999, 256), 1'b0);
        else if (r < 95)
            add_number($urandom_range(9999, 1000), 1'b0);
        // else empty part
    endfunction

    // Mostly 1 to 4 hex digits of mixed case, sometimes 0 or 5
    function void add_v6_part();
        int         len;
        int         i;
        logic [3:0] n;
        len = ($urandom_range(9) == 0) ? 5 * $urandom_range(1) : $urandom_range(4, 1);
        for (i = 0; i < len; i++)
        begin
            n = 4'($urandom);
            if (n < 10)
                put_char(DEC_LO + n);
            else if ($urandom_range(1))
                put_char(8'(UHEX_LO + n - 10));
            else
                put_char(8'(LHEX_LO + n - 10));
        end
    endfunction

    function void build_v4();
        int i;
        for (i = 0; i < 4; i++)
        begin
            if (i != 0)
                put_char(DOT_CHAR);
            add_v4_part();
        end
    endfunction

    function void build_v6();
        int i;
        for (i = 0; i < 8; i++)
        begin
            if (i != 0)
                put_char(COLON_CHAR);
            add_v6_part();
        end
    endfunction

    // Break a well-formed string in one place
    function void mutate_text();
        int         pos;
        logic [7:0] sep;
        if (text.size() == 0)
            return;
        pos = $urandom_range(text.size() - 1);
        sep = $urandom_range(1) ? DOT_CHAR : COLON_CHAR;
        case ($urandom_range(3))
            0: text[pos] = 8'($urandom);
            1: text.delete(pos);
            2: text.insert(pos, sep);
            default: put_char(sep);
        endcase
    endfunction

    // Short strings weighted toward digits and separators
    function void build_noise();
        int len;
        int i;
        int r;
        len = $urandom_range(16);
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                put_char(8'(DEC_LO + $urandom_range(9)));
            else if (r < 55)
                put_char(DOT_CHAR);
            else if (r < 70)
                put_char(COLON_CHAR);
            else if (r < 85)
                put_char(8'(LHEX_LO + $urandom_range(5)));
            else
                put_char(8'($urandom));
        end
    endfunction

    task send_random_string();
        int r;
        text.delete();
        r = $urandom_range(99);
        if (r < 35)
            build_v4();
        else if (r < 70)
            build_v6();
        else if (r < 88)
        begin
            if ($urandom_range(1))
                build_v4();
            else
                build_v6();
            mutate_text();
        end
        else
            build_noise();
        send_text($urandom_range(4) == 0, 4);
    endtask

    task run_random(input int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target)
            send_random_string();
    endtask

    // Stimulus and end of run
    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        send_idle  = 30;
        recv_idle  = 81;
        beats_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty string, byte extremes, ignored beat, absent last byte,
        // trailing and doubled separators
        load_text("");
        send_text(1'b0, 0);
        text.delete();
        put_char(8'hFF);
        send_text(1'b0, 0);
        text.delete();
        put_char(8'h00);
        send_text(1'b0, 0);
        load_text("9.1.0.4");
        send_beat(8'hFF, 1'b0, 1'b0);
        send_text(1'b1, 0);
        load_text("1.2.3.");
        send_text(1'b0, 0);
        load_text("1..2.3");
        send_text(1'b0, 0);

        run_random(ITEMS_PER_PHASE);
        send_idle = 81;
        recv_idle = 30;
        run_random(ITEMS_PER_PHASE);
        send_idle = 0;
        recv_idle = 0;
        run_random(ITEMS_PER_PHASE);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_kinds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.report_leftover();
        if (sb.mismatches == 0)
            $display("PASS ip_address_text_classifier");
        else
            $display("FAIL ip_address_text_classifier");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ipatc_pkg.sv
rtl/ipatc_front.sv
rtl/ipatc_queue.sv
rtl/ipatc_back.sv
rtl/ip_address_text_classifier.sv
rtl/ipatc_checker.sv
sim/tb.sv
